### sv/cnhp_pkg.sv
// cnhp_pkg: shared types, codes and character tables for the newc header parser.
// Used by cnhp_parser, cnhp_queue and cpio_newc_header_parser. No dependencies.
package cnhp_pkg;

  // Default limit on the name length field (name plus its NUL)
  localparam int unsigned MaxNameLenDef = 4096;

  // Result queue between the parser and the output port
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Result kinds
  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_NAME    = 3'd1,
    KIND_DATA    = 3'd2,
    KIND_TRAILER = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_e;

  // Error codes
  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_MAGIC     = 4'd1,
    ERR_HEX_DIGIT = 4'd2,
    ERR_HEX_NUM   = 4'd3,
    ERR_NAME_LEN  = 4'd4,
    ERR_SHORT     = 4'd5,
    ERR_SPACE     = 4'd6,
    ERR_UNPRINT   = 4'd7,
    ERR_NO_NUL    = 4'd8,
    ERR_NAME_LONG = 4'd9
  } err_e;

  // One result beat
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic [31:0] file_size;
    err_e        error_code;
    logic        last_data;
  } res_t;

  // Hex digit decode result
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } hex_t;

  // Expected magic character "070701"; index wraps modulo 6
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0, 3'd2, 3'd4, 3'd6: ch = 8'h30;  // '0'
      3'd1, 3'd3, 3'd7:       ch = 8'h37;  // '7'
      3'd5:                   ch = 8'h31;  // '1'
      default:                ch = 8'h30;
    endcase
    return ch;
  endfunction

  // Trailer name "TRAILER!!!"
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h54;  // T
      4'd1:    ch = 8'h52;  // R
      4'd2:    ch = 8'h41;  // A
      4'd3:    ch = 8'h49;  // I
      4'd4:    ch = 8'h4C;  // L
      4'd5:    ch = 8'h45;  // E
      4'd6:    ch = 8'h52;  // R
      4'd7,
      4'd8,
      4'd9:    ch = 8'h21;  // !
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // ASCII hex digit, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.digit = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.valid = 1'b1;
      h.digit = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return h;
  endfunction

endpackage

### sv/cnhp_parser.sv
// cnhp_parser: front end. Takes one stream byte per beat, tracks the member
// layout and produces at most one result per byte. Depends on cnhp_pkg.
module cnhp_parser #(
  parameter int unsigned MAX_NAME_LEN = cnhp_pkg::MaxNameLenDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          byte_valid_i,
  input  logic [7:0]    byte_i,
  output logic          res_push_o,
  output cnhp_pkg::res_t res_o
);
  import cnhp_pkg::*;

  localparam int unsigned NameW = $clog2(MAX_NAME_LEN + 1);
  localparam logic [31:0] MaxLen32 = 32'(MAX_NAME_LEN);
  localparam logic [NameW-1:0] TrailerLen = NameW'(11);

  typedef enum logic [3:0] {
    PH_MAGIC, PH_HEX, PH_NAME, PH_NUL, PH_NPAD,
    PH_DATA, PH_DPAD, PH_DONE, PH_ERROR
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [3:0]       field_q, field_d;
  logic [3:0]       digit_q, digit_d;
  logic [31:0]      hex_q, hex_d;
  logic             blank_q, blank_d;
  logic [31:0]      data_len_q, data_len_d;
  logic [NameW-1:0] name_len_q, name_len_d;
  logic [NameW-1:0] name_cnt_q, name_cnt_d;
  logic             trl_q, trl_d;
  logic [1:0]       pos_q, pos_d;
  logic [31:0]      remain_q, remain_d;

  hex_t        hx;
  logic [31:0] hex_new;
  logic [3:0]  digit_inc;

  assign hx        = hex_decode(byte_i);
  assign hex_new   = {hex_q[27:0], hx.digit};
  assign digit_inc = digit_q + 4'd1;

  // Next state and result for one byte
  always_comb begin
    phase_d    = phase_q;
    field_d    = field_q;
    digit_d    = digit_q;
    hex_d      = hex_q;
    blank_d    = blank_q;
    data_len_d = data_len_q;
    name_len_d = name_len_q;
    name_cnt_d = name_cnt_q;
    trl_d      = trl_q;
    pos_d      = pos_q;
    remain_d   = remain_q;
    res_push_o = 1'b0;
    res_o      = '0;

    if (byte_valid_i && phase_q != PH_DONE && phase_q != PH_ERROR) begin
      pos_d = pos_q + 2'd1;
      case (phase_q)
        PH_MAGIC: begin
          if (byte_i != magic_char(digit_q[2:0])) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_MAGIC;
          end else if (digit_inc >= 4'd6) begin
            phase_d = PH_HEX;
            field_d = '0;
            digit_d = '0;
            hex_d   = '0;
            blank_d = 1'b1;
          end else begin
            digit_d = digit_inc;
          end
        end

        PH_HEX: begin
          if (!hx.valid && byte_i != 8'h20) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_HEX_DIGIT;
          end else if (!hx.valid && !blank_q) begin
            // space after a digit
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_HEX_NUM;
          end else begin
            hex_d   = hex_new;
            digit_d = digit_inc;
            if (hx.valid) blank_d = 1'b0;
            if (digit_inc >= 4'd8) begin
              if (blank_q && !hx.valid) begin
                // all-space field
                phase_d          = PH_ERROR;
                res_push_o       = 1'b1;
                res_o.kind       = KIND_ERROR;
                res_o.error_code = ERR_HEX_NUM;
              end else if (field_q == 4'd11 && hex_new < 32'd2) begin
                phase_d          = PH_ERROR;
                res_push_o       = 1'b1;
                res_o.kind       = KIND_ERROR;
                res_o.error_code = ERR_NAME_LEN;
              end else if (field_q == 4'd11 && hex_new > MaxLen32) begin
                phase_d          = PH_ERROR;
                res_push_o       = 1'b1;
                res_o.kind       = KIND_ERROR;
                res_o.error_code = ERR_NAME_LONG;
              end else begin
                if (field_q == 4'd6)  data_len_d = hex_new;
                if (field_q == 4'd11) name_len_d = hex_new[NameW-1:0];
                digit_d = '0;
                hex_d   = '0;
                blank_d = 1'b1;
                if (field_q >= 4'd12) begin
                  phase_d    = PH_NAME;
                  name_cnt_d = '0;
                  trl_d      = 1'b1;
                end else begin
                  field_d = field_q + 4'd1;
                end
              end
            end
          end
        end

        PH_NAME: begin
          if (byte_i == 8'h00) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_SHORT;
          end else if (byte_i == 8'h20 || (byte_i >= 8'd9 && byte_i <= 8'd13)) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_SPACE;
          end else if (byte_i < 8'd33 || byte_i > 8'd126) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_UNPRINT;
          end else begin
            if (name_cnt_q >= NameW'(10) ||
                trailer_char(name_cnt_q[3:0]) != byte_i) begin
              trl_d = 1'b0;
            end
            name_cnt_d = name_cnt_q + NameW'(1);
            if (name_cnt_d >= name_len_q - NameW'(1)) phase_d = PH_NUL;
            res_push_o     = 1'b1;
            res_o.kind     = KIND_NAME;
            res_o.out_byte = byte_i;
          end
        end

        PH_NUL, PH_NPAD: begin
          if (phase_q == PH_NUL && byte_i != 8'h00) begin
            phase_d          = PH_ERROR;
            res_push_o       = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NO_NUL;
          end else if (pos_d == 2'd0) begin
            // header complete at the 4-byte boundary
            res_push_o = 1'b1;
            if (trl_q && name_len_q == TrailerLen) begin
              phase_d    = PH_DONE;
              res_o.kind = KIND_TRAILER;
            end else begin
              remain_d        = data_len_q;
              phase_d         = (data_len_q != '0) ? PH_DATA : PH_MAGIC;
              digit_d         = '0;
              res_o.kind      = KIND_HEADER;
              res_o.file_size = data_len_q;
            end
          end else begin
            phase_d = PH_NPAD;
          end
        end

        PH_DATA: begin
          remain_d       = remain_q - 32'd1;
          res_push_o     = 1'b1;
          res_o.kind     = KIND_DATA;
          res_o.out_byte = byte_i;
          if (remain_d == '0) begin
            phase_d         = (pos_d != 2'd0) ? PH_DPAD : PH_MAGIC;
            digit_d         = '0;
            res_o.last_data = 1'b1;
          end
        end

        PH_DPAD: begin
          if (pos_d == 2'd0) begin
            phase_d = PH_MAGIC;
            digit_d = '0;
          end
        end

        default: begin
          phase_d = PH_ERROR;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_MAGIC;
      field_q    <= '0;
      digit_q    <= '0;
      hex_q      <= '0;
      blank_q    <= 1'b1;
      data_len_q <= '0;
      name_len_q <= '0;
      name_cnt_q <= '0;
      trl_q      <= 1'b1;
      pos_q      <= '0;
      remain_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      field_q    <= field_d;
      digit_q    <= digit_d;
      hex_q      <= hex_d;
      blank_q    <= blank_d;
      data_len_q <= data_len_d;
      name_len_q <= name_len_d;
      name_cnt_q <= name_cnt_d;
      trl_q      <= trl_d;
      pos_q      <= pos_d;
      remain_q   <= remain_d;
    end
  end

endmodule

### sv/cnhp_queue.sv
// cnhp_queue: back end. Short result queue that holds parser results and
// presents them on the output channel. Depends on cnhp_pkg.
module cnhp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cnhp_pkg::res_t push_data_i,
  output logic           full_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cnhp_pkg::res_t out_data_o
);
  import cnhp_pkg::*;

  res_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 pop;

  assign full_o      = (cnt_q == QueueCntW'(QueueDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + QueuePtrW'(1);
      if (pop)    rd_q <= rd_q + QueuePtrW'(1);
      if (push_i && !pop)      cnt_q <= cnt_q + QueueCntW'(1);
      else if (pop && !push_i) cnt_q <= cnt_q - QueueCntW'(1);
    end
  end

endmodule

### sv/cpio_newc_header_parser.sv
// cpio_newc_header_parser: top level of the newc archive header parser.
// Depends on cnhp_pkg, cnhp_parser and cnhp_queue.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_byte_i) carries the archive
//   stream, one byte per beat. Output channel (out_valid_o / out_ready_i)
//   carries results: header done with file size, name bytes, data bytes
//   (last_data_o on the final one), end trailer, or an error code.
//   Throughput: one byte per cycle while the receiver takes results.
//   The parser decodes each byte in the cycle it is accepted and writes at
//   most one result into a two-entry queue; the queue read side drives the
//   output ports, so each result is registered before it is presented.
//   When the receiver stalls, bytes are still taken until the queue is
//   full; in_ready_o then drops until a result is taken.
//   Padding and header digits give no result. After the trailer or an
//   error, bytes are accepted and dropped until reset.
//   Reset (rst_ni low, asynchronous) empties the queue and returns the
//   parser to waiting for the magic at stream position zero.
module cpio_newc_header_parser #(
  parameter int unsigned MAX_NAME_LEN = cnhp_pkg::MaxNameLenDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          in_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cnhp_pkg::kind_e     kind_o,
  output logic [7:0]          out_byte_o,
  output logic [31:0]         file_size_o,
  output cnhp_pkg::err_e      error_code_o,
  output logic                last_data_o
);
  import cnhp_pkg::*;

  logic full, in_beat, push;
  res_t res, out_res;

  assign in_ready_o = !full;
  assign in_beat    = in_valid_i && in_ready_o;

  // Front end: byte decode
  cnhp_parser #(
    .MAX_NAME_LEN(MAX_NAME_LEN)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_beat),
    .byte_i       (in_byte_i),
    .res_push_o   (push),
    .res_o        (res)
  );

  // Back end: result queue and output channel
  cnhp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign kind_o       = out_res.kind;
  assign out_byte_o   = out_res.out_byte;
  assign file_size_o  = out_res.file_size;
  assign error_code_o = out_res.error_code;
  assign last_data_o  = out_res.last_data;

  // Only error beats carry an error code
  a_code_only_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o != KIND_ERROR) |-> error_code_o == ERR_NONE)
    else $error("error code on a non-error beat");

  // last_data only marks data beats
  a_last_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_data_o) |-> kind_o == KIND_DATA)
    else $error("last_data on a non-data beat");

  // Nothing follows an error beat
  a_error_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && kind_o == KIND_ERROR) |=> !out_valid_o)
    else $error("result after an error beat");

  // Backpressure only with results waiting
  a_stall_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty queue");

endmodule

### bench/cpio_newc_header_parser_tb.sv
// Testbench for cpio_newc_header_parser: streams newc archive members through the
// parser and checks every result beat against a cycle-free predictor of the parser.
// Depends on cnhp_pkg and the cpio_newc_header_parser RTL.
`timescale 1ns / 1ps

module cpio_newc_header_parser_tb;
  import cnhp_pkg::*;

  localparam int unsigned MaxNameLen = MaxNameLenDef;
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned RandomBytes = 520;
  localparam logic [47:0] MagicTxt = "070701";
  localparam logic [79:0] TrailerTxt = "TRAILER!!!";

  typedef logic [7:0] byte_q_t[$];

  typedef enum logic [3:0] {
    ST_MAGIC, ST_HEX, ST_NAME, ST_NUL, ST_NPAD, ST_DATA, ST_DPAD, ST_DONE, ST_ERROR
  } scan_state_e;

  // Predicts the parser byte by byte and holds the results still owed by the DUT
  class newc_result_board;
    scan_state_e scan = ST_MAGIC;
    int unsigned fld = 0;
    int unsigned digits = 0;
    logic [31:0] acc = '0;
    bit          blank = 1'b1;
    logic [31:0] data_len = '0;
    logic [31:0] name_len = '0;
    logic [31:0] name_cnt = '0;
    bit          trl = 1'b1;
    logic [1:0]  pos = '0;
    logic [31:0] remain = '0;
    res_t        expected_results[$];
    int unsigned mismatches = 0;

    function void push_result(kind_e k, logic [7:0] b, logic [31:0] sz, err_e e, logic last);
      res_t r;
      r.kind       = k;
      r.out_byte   = b;
      r.file_size  = sz;
      r.error_code = e;
      r.last_data  = last;
      expected_results.insert(expected_results.size(), r);
    endfunction

    function void fail_with(err_e e);
      scan = ST_ERROR;
      push_result(KIND_ERROR, 8'h00, 32'h0, e, 1'b0);
    endfunction

    // Name and padding done: header result or end of archive
    function void close_header();
      if (trl && name_len == 32'd11) begin
        scan = ST_DONE;
        push_result(KIND_TRAILER, 8'h00, 32'h0, ERR_NONE, 1'b0);
      end else begin
        remain = data_len;
        scan   = (data_len != 0) ? ST_DATA : ST_MAGIC;
        digits = 0;
        push_result(KIND_HEADER, 8'h00, data_len, ERR_NONE, 1'b0);
      end
    endfunction

    // One accepted input beat
    function void take_byte(logic [7:0] c);
      logic [3:0] d;
      if (scan == ST_DONE || scan == ST_ERROR) return;
      pos = pos + 2'd1;
      case (scan)
        ST_MAGIC: begin
          if (c != MagicTxt[47 - 8*digits -: 8]) begin
            fail_with(ERR_MAGIC);
            return;
          end
          digits++;
          if (digits >= 6) begin
            scan   = ST_HEX;
            fld    = 0;
            digits = 0;
            acc    = '0;
            blank  = 1'b1;
          end
        end
        ST_HEX: begin
          if (c >= "0" && c <= "9") begin
            d = 4'(c - "0");
            blank = 1'b0;
          end else if (c >= "a" && c <= "f") begin
            d = 4'(c - "a" + 10);
            blank = 1'b0;
          end else if (c >= "A" && c <= "F") begin
            d = 4'(c - "A" + 10);
            blank = 1'b0;
          end else if (c == " ") begin
            // a space only counts as a zero before the first digit
            if (!blank) begin
              fail_with(ERR_HEX_NUM);
              return;
            end
            d = 4'd0;
          end else begin
            fail_with(ERR_HEX_DIGIT);
            return;
          end
          acc = {acc[27:0], d};
          digits++;
          if (digits < 8) return;
          if (blank) begin
            fail_with(ERR_HEX_NUM);
            return;
          end
          if (fld == 6) data_len = acc;
          if (fld == 11) begin
            name_len = acc;
            if (name_len < 2) begin
              fail_with(ERR_NAME_LEN);
              return;
            end
            if (name_len > MaxNameLen) begin
              fail_with(ERR_NAME_LONG);
              return;
            end
          end
          digits = 0;
          acc    = '0;
          blank  = 1'b1;
          if (fld >= 12) begin
            scan     = ST_NAME;
            name_cnt = '0;
            trl      = 1'b1;
          end else begin
            fld++;
          end
        end
        ST_NAME: begin
          if (c == 8'h00) fail_with(ERR_SHORT);
          else if (c == " " || (c >= 8'd9 && c <= 8'd13)) fail_with(ERR_SPACE);
          else if (c < 8'd33 || c > 8'd126) fail_with(ERR_UNPRINT);
          else begin
            if (name_cnt >= 10 || TrailerTxt[79 - 8*name_cnt -: 8] != c) trl = 1'b0;
            name_cnt++;
            if (name_cnt >= name_len - 1) scan = ST_NUL;
            push_result(KIND_NAME, c, 32'h0, ERR_NONE, 1'b0);
          end
        end
        ST_NUL: begin
          if (c != 8'h00) fail_with(ERR_NO_NUL);
          else if (pos == 2'd0) close_header();
          else scan = ST_NPAD;
        end
        ST_NPAD: begin
          if (pos == 2'd0) close_header();
        end
        ST_DATA: begin
          remain--;
          if (remain == 0) begin
            scan   = (pos != 2'd0) ? ST_DPAD : ST_MAGIC;
            digits = 0;
            push_result(KIND_DATA, c, 32'h0, ERR_NONE, 1'b1);
          end else begin
            push_result(KIND_DATA, c, 32'h0, ERR_NONE, 1'b0);
          end
        end
        ST_DPAD: begin
          if (pos == 2'd0) begin
            scan   = ST_MAGIC;
            digits = 0;
          end
        end
        default: scan = ST_ERROR;
      endcase
    endfunction

    // One accepted result beat against the oldest expectation
    function void compare_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: kind %0d", got.kind);
        mismatches++;
        return;
      end
      e = expected_results.pop_front();
      if (got.kind !== e.kind) begin
        $error("kind: expected %0d, got %0d", e.kind, got.kind);
        mismatches++;
      end
      if (got.out_byte !== e.out_byte) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", e.out_byte, got.out_byte);
        mismatches++;
      end
      if (got.file_size !== e.file_size) begin
        $error("file_size: expected 0x%08h, got 0x%08h", e.file_size, got.file_size);
        mismatches++;
      end
      if (got.error_code !== e.error_code) begin
        $error("error_code: expected %0d, got %0d", e.error_code, got.error_code);
        mismatches++;
      end
      if (got.last_data !== e.last_data) begin
        $error("last_data: expected %0b, got %0b", e.last_data, got.last_data);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  kind_e       kind_o;
  logic [7:0]  out_byte_o;
  logic [31:0] file_size_o;
  err_e        error_code_o;
  logic        last_data_o;

  newc_result_board sb = new;
  int unsigned send_idle_pct = 15;
  int unsigned recv_idle_pct = 62;
  int unsigned stream_pos = 0;
  int unsigned cycle_cnt = 0;

  cpio_newc_header_parser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .file_size_o  (file_size_o),
    .error_code_o (error_code_o),
    .last_data_o  (last_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Watch both channels at the rising edge
  always @(posedge clk_i) begin : watch
    res_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.take_byte(in_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.kind       = kind_o;
        got.out_byte   = out_byte_o;
        got.file_size  = file_size_o;
        got.error_code = error_code_o;
        got.last_data  = last_data_o;
        sb.compare_result(got);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive a list of bytes, one beat each, with random sender gaps
  task automatic send_stream(input byte_q_t q);
    foreach (q[i]) begin
      @(negedge clk_i);
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= q[i];
      do @(posedge clk_i); while (!in_ready_o);
      stream_pos++;
    end
  endtask

  // Printable name; near_trailer starts it with the trailer text but never matches it
  function automatic byte_q_t make_name(input int unsigned n, input bit near_trailer);
    byte_q_t nm;
    int unsigned k;
    for (int i = 0; i < n; i++)
      nm.insert(nm.size(), (near_trailer && i < 10) ? TrailerTxt[79 - 8*i -: 8]
                                                    : 8'($urandom_range(33, 126)));
    if (near_trailer && n == 10) begin
      k = $urandom_range(0, 9);
      do nm[k] = 8'($urandom_range(33, 126)); while (nm[k] == TrailerTxt[79 - 8*k -: 8]);
    end
    return nm;
  endfunction

  // One member laid out from the current stream position: magic, 13 fields,
  // name, NUL, pad, data_cnt data bytes, and the data pad if all data is there
  function automatic void build_member(output byte_q_t q, input logic [31:0] fsize,
                                       input logic [31:0] nlen, input byte_q_t nm,
                                       input int unsigned data_cnt);
    logic [31:0] v;
    logic [3:0]  nib;
    int unsigned lead, nsp, p;
    q = {};
    for (int i = 0; i < 6; i++) q.insert(q.size(), MagicTxt[47 - 8*i -: 8]);
    for (int f = 0; f < 13; f++) begin
      case ($urandom_range(0, 3))
        0:       v = 32'h0;
        1:       v = $urandom_range(0, 255);
        default: v = $urandom;
      endcase
      if (f == 6) v = fsize;
      if (f == 11) v = nlen;
      // leading zeros may be sent as spaces, mixed-case digits otherwise
      lead = 0;
      while (lead < 7 && v[31 - 4*lead -: 4] == 4'h0) lead++;
      nsp = $urandom_range(0, 1) ? $urandom_range(0, lead) : 0;
      for (int j = 0; j < 8; j++) begin
        nib = v[31 - 4*j -: 4];
        if (j < nsp) q.insert(q.size(), 8'h20);
        else if (nib < 4'd10) q.insert(q.size(), 8'h30 + 8'(nib));
        else q.insert(q.size(), ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(nib) - 8'd10);
      end
    end
    foreach (nm[i]) q.insert(q.size(), nm[i]);
    q.insert(q.size(), 8'h00);
    p = stream_pos + q.size();
    while (p % 4 != 0) begin
      q.insert(q.size(), 8'($urandom_range(0, 255)));
      p++;
    end
    for (int i = 0; i < data_cnt; i++) q.insert(q.size(), 8'($urandom_range(0, 255)));
    if (data_cnt == fsize) begin
      p = stream_pos + q.size();
      while (p % 4 != 0) begin
        q.insert(q.size(), 8'($urandom_range(0, 255)));
        p++;
      end
    end
  endfunction

  task automatic send_member(input logic [31:0] fsize, input byte_q_t nm,
                             output int unsigned nbytes);
    byte_q_t q;
    build_member(q, fsize, nm.size() + 1, nm, fsize);
    nbytes = q.size();
    send_stream(q);
  endtask

  // Final member: trailer, huge data, or one error; then ignored noise
  task automatic send_ending();
    byte_q_t q, nm;
    err_e        code;
    logic [31:0] fsize, nlen;
    logic [7:0]  bad;
    int unsigned idx, base, j, dcnt;
    code  = err_e'($urandom_range(0, 9));
    nm    = make_name($urandom_range(1, 12), 1'b0);
    fsize = $urandom_range(0, 8);
    dcnt  = fsize;
    if (code == ERR_NONE) begin
      if ($urandom_range(0, 1)) begin
        nm = {};
        for (int i = 0; i < 10; i++) nm.insert(nm.size(), TrailerTxt[79 - 8*i -: 8]);
        fsize = $urandom;
        dcnt  = 0;
      end else begin
        fsize = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        dcnt  = $urandom_range(1, 24);
      end
    end
    nlen = nm.size() + 1;
    if (code == ERR_NAME_LEN) nlen = $urandom_range(0, 1);
    if (code == ERR_NAME_LONG) begin
      case ($urandom_range(0, 2))
        0:       nlen = MaxNameLen + 1;
        1:       nlen = 32'hFFFF_FFFF;
        default: nlen = $urandom_range(MaxNameLen + 1, 32'hFFFF_FFFF);
      endcase
    end
    build_member(q, fsize, nlen, nm, dcnt);
    idx = q.size() - 1;
    bad = q[idx];
    case (code)
      ERR_MAGIC: begin
        idx = $urandom_range(0, 5);
        bad = q[idx] ^ 8'($urandom_range(1, 255));
      end
      ERR_HEX_DIGIT: begin
        idx = $urandom_range(6, 109);
        do bad = 8'($urandom_range(0, 255));
        while ((bad >= "0" && bad <= "9") || (bad >= "a" && bad <= "f") ||
               (bad >= "A" && bad <= "F") || bad == " ");
      end
      ERR_HEX_NUM: begin
        base = 6 + 8 * $urandom_range(0, 12);
        if ($urandom_range(0, 1)) begin
          // field of blanks only
          for (int k = 0; k < 8; k++) q[base + k] = 8'h20;
          idx = base + 7;
        end else begin
          // blank after a digit
          j = $urandom_range(1, 7);
          for (int k = 0; k < j; k++) q[base + k] = "A";
          idx = base + j;
        end
        bad = 8'h20;
      end
      ERR_NAME_LEN, ERR_NAME_LONG: begin
        idx = 109;
        bad = q[idx];
      end
      ERR_SHORT: begin
        idx = 110 + $urandom_range(0, nm.size() - 1);
        bad = 8'h00;
      end
      ERR_SPACE: begin
        idx = 110 + $urandom_range(0, nm.size() - 1);
        j   = $urandom_range(0, 5);
        bad = (j == 5) ? 8'h20 : 8'(9 + j);
      end
      ERR_UNPRINT: begin
        idx = 110 + $urandom_range(0, nm.size() - 1);
        do bad = 8'($urandom_range(1, 255));
        while ((bad >= 8'd9 && bad <= 8'd13) || (bad >= 8'd32 && bad <= 8'd126));
      end
      ERR_NO_NUL: begin
        idx = 110 + nm.size();
        bad = 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    q[idx] = bad;
    q = q[0:idx];
    send_stream(q);
    // parser is stopped now unless the member has huge data; then these beats are data
    q = {};
    repeat ($urandom_range(4, 20)) q.insert(q.size(), 8'($urandom_range(0, 255)));
    send_stream(q);
  endtask

  initial begin
    int unsigned random_cnt, nbytes, n, drain;
    logic [31:0] fsize;
    bit          near;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed members: shortest name with no data, near-trailer names,
    // a long name
    send_member(32'd0, make_name(1, 1'b0), nbytes);
    send_member(32'd4, make_name(9, 1'b1), nbytes);
    send_member(32'd1, make_name(11, 1'b1), nbytes);
    send_member(32'd3, make_name(10, 1'b1), nbytes);
    send_member(32'd2, make_name(120, 1'b0), nbytes);

    // Random well-formed members across the three idling phases
    random_cnt = 0;
    while (random_cnt < RandomBytes) begin
      if (random_cnt < RandomBytes / 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 62;
      end else if (random_cnt < 2 * RandomBytes / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      near  = ($urandom_range(0, 5) == 0);
      n     = near ? $urandom_range(8, 12)
            : (($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24));
      fsize = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 40);
      send_member(fsize, make_name(n, near), nbytes);
      random_cnt += nbytes;
    end

    send_ending();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    drain = 0;
    while (sb.pending() != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d result beats never arrived", sb.pending());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
sv/cnhp_pkg.sv
sv/cnhp_parser.sv
sv/cnhp_queue.sv
sv/cpio_newc_header_parser.sv
bench/cpio_newc_header_parser_tb.sv
